// ===== hdl/b64lw_pkg.sv =====
package b64lw_pkg;

    // Payload of one input transaction.
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_item_t;

    // Payload of one output transaction.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_item_t;

    // Input action codes.
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // How many padding characters close a character group.
    typedef enum logic [1:0] {
        GRP_FULL,
        GRP_PAD1,
        GRP_PAD2
    } grp_kind_t;

    // One unit of work for the character serializer.
    typedef struct packed {
        logic [23:0] bits;
        grp_kind_t   kind;
        logic        crlf;
    } job_t;

    localparam logic [6:0] WRAP_RESET = 7'd72;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_PAD     = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    // Character positions within one job.
    localparam logic [2:0] IDX_C0 = 3'd0;
    localparam logic [2:0] IDX_C1 = 3'd1;
    localparam logic [2:0] IDX_C2 = 3'd2;
    localparam logic [2:0] IDX_C3 = 3'd3;
    localparam logic [2:0] IDX_CR = 3'd4;
    localparam logic [2:0] IDX_LF = 3'd5;

    // Maps a six-bit value onto the standard Base64 alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] k);
        logic [7:0] k8;
        logic [7:0] r;
        k8 = {2'b00, k};
        if (k8 < 8'd26)
            r = k8 + 8'h41;
        else if (k8 < 8'd52)
            r = k8 + 8'd71;
        else if (k8 < 8'd62)
            r = k8 - 8'd4;
        else if (k8 == 8'd62)
            r = CH_PLUS;
        else
            r = CH_SLASH;
        return r;
    endfunction

endpackage

// ===== hdl/b64lw_front.sv =====
module b64lw_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_ready,
    input  b64lw_pkg::in_item_t src_item,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               q_full,
    output logic               q_push,
    output b64lw_pkg::job_t    q_job
);
    import b64lw_pkg::*;

    logic [6:0]  wrap_reg;
    logic [15:0] held_reg;
    logic [15:0] held_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [6:0]  column_reg;
    logic [6:0]  column_next;
    logic [7:0]  col_sum;
    logic        take;

    assign src_ready = !q_full;
    assign take      = src_valid && src_ready;
    assign col_sum   = {1'b0, column_reg} + 8'd4;

    always_comb
    begin
        held_next   = held_reg;
        count_next  = count_reg;
        column_next = column_reg;
        q_push      = 1'b0;
        q_job.bits  = {held_reg, src_item.data_byte};
        q_job.kind  = GRP_FULL;
        q_job.crlf  = 1'b0;
        if (take)
        begin
            if (src_item.action == ACT_FLUSH)
            begin
                held_next  = '0;
                count_next = '0;
                q_push     = (count_reg != 2'd0);
                if (count_reg == 2'd1)
                begin
                    q_job.bits = {held_reg[7:0], 16'h0000};
                    q_job.kind = GRP_PAD2;
                end
                else
                begin
                    q_job.bits = {held_reg, 8'h00};
                    q_job.kind = GRP_PAD1;
                end
            end
            else if (count_reg < 2'd2)
            begin
                held_next  = {held_reg[7:0], src_item.data_byte};
                count_next = count_reg + 2'd1;
            end
            else
            begin
                held_next  = '0;
                count_next = '0;
                q_push     = 1'b1;
                q_job.crlf = (col_sum >= {1'b0, wrap_reg});
                column_next = q_job.crlf ? 7'd0 : col_sum[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg   <= WRAP_RESET;
            held_reg   <= '0;
            count_reg  <= '0;
            column_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                wrap_reg <= cfg_wdata;
            held_reg   <= held_next;
            count_reg  <= count_next;
            column_reg <= column_next;
        end
    end

endmodule

// ===== hdl/b64lw_queue.sv =====
module b64lw_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64lw_pkg::job_t push_job,
    input  logic            pop,
    output b64lw_pkg::job_t head_job,
    output logic            full,
    output logic            empty
);
    import b64lw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from an empty queue");

endmodule

// ===== hdl/b64lw_back.sv =====
module b64lw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  b64lw_pkg::job_t     head_job,
    output logic                q_pop,
    output logic                dst_valid,
    input  logic                dst_ready,
    output b64lw_pkg::out_item_t dst_item
);
    import b64lw_pkg::*;

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_reg;
    logic       advance;
    logic       is_last;
    logic [7:0] ch;

    assign advance   = !q_empty && (!out_valid_reg || dst_ready);
    assign is_last   = head_job.crlf ? (idx_reg == IDX_LF) : (idx_reg == IDX_C3);
    assign q_pop     = advance && is_last;
    assign dst_valid = out_valid_reg;
    assign dst_item  = out_reg;

    always_comb
    begin
        case (idx_reg)
            IDX_C0:  ch = sextet_char(head_job.bits[23:18]);
            IDX_C1:  ch = sextet_char(head_job.bits[17:12]);
            IDX_C2:  ch = (head_job.kind == GRP_PAD2) ? CH_PAD
                                                      : sextet_char(head_job.bits[11:6]);
            IDX_C3:  ch = (head_job.kind != GRP_FULL) ? CH_PAD
                                                      : sextet_char(head_job.bits[5:0]);
            IDX_CR:  ch = CH_CR;
            IDX_LF:  ch = CH_LF;
            default: ch = CH_PAD;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? IDX_C0 : idx_reg + 3'd1;
        end
        else if (dst_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= IDX_C0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_char <= ch;
            out_reg.last     <= is_last;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LF)
        else $error("character index out of range");

    a_break_only_on_crlf: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg == IDX_CR || idx_reg == IDX_LF) |-> (!q_empty && head_job.crlf))
        else $error("line break position on a job without a line break");

    a_restart_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == IDX_C0))
        else $error("character index not rewound after a finished job");

endmodule

// ===== hdl/base64_line_wrap_encoder.sv =====
// Channel | Signals                          | Transaction
// --------+----------------------------------+-------------------------------------------
// source  | src_valid, src_ready, src_item   | one raw byte or one flush request
// sink    | dst_valid, dst_ready, dst_item   | one output character, last on the final one
// config  | cfg_we, cfg_wdata                | write of the wrap column, no wait
//
// A source transaction is taken whenever the job queue has room; bytes that do not
// complete a group and empty flushes are absorbed without any output.
// The sink side sends one character per cycle while dst_ready is high; a group is four
// characters, or six with CR LF, and the serializer in the back end sets the sustained rate.
// Reset (rst_n low, asynchronous) clears the held bytes, the column, the queue and the
// output valid flag, and loads a wrap column of 72.
// A stalled sink fills the queue and then lowers src_ready; either side may stall freely.
module base64_line_wrap_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_ready,
    input  b64lw_pkg::in_item_t  src_item,
    output logic                 dst_valid,
    input  logic                 dst_ready,
    output b64lw_pkg::out_item_t dst_item,
    input  logic                 cfg_we,
    input  logic [6:0]           cfg_wdata
);
    import b64lw_pkg::*;

    // Jobs handed from the front end to the serializer. A job is a 24-bit group, the
    // amount of padding it needs, and whether a line break follows it.
    job_t push_job;
    job_t head_job;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // The front end gathers bytes, keeps the line column and decides on line breaks,
    // so the serializer never needs to know about the column.
    b64lw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    // The queue decouples the two halves, so new bytes keep flowing in while the
    // serializer is still writing out an earlier group.
    b64lw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // The back end walks the head job one character per cycle, while the sink is ready, into a registered output.
    b64lw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_job  (head_job),
        .q_pop     (q_pop),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_item  (dst_item)
    );

endmodule

// ===== bench/base64_line_wrap_encoder_test.sv =====
`timescale 1ns / 1ps

module base64_line_wrap_encoder_test;

    import b64lw_pkg::*;

    // Generous bound on the whole run. The slowest correct run has about 255 input
    // transactions, each causing up to six characters that each may wait out the longest
    // receiver stall, plus sender gaps and one long receiver hold-off.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 200;
    localparam int SETTLE_TICKS = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_ready;
    in_item_t   src_item = '0;
    logic       dst_valid;
    logic       dst_ready = 1'b0;
    out_item_t  dst_item;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;

    base64_line_wrap_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_item  (dst_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Items waiting to be offered, and the characters the encoder still owes us.
    in_item_t  byte_queue[$];
    out_item_t expected_chars[$];

    int  items_queued = 0;
    int  items_taken = 0;
    int  errors = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    int  hold_request = 0;
    // Set at a rising edge when the source transaction on offer was taken.
    logic src_taken = 1'b0;

    // Our own view of the encoder state: held bytes, how many, the line column
    // and the current wrap setting (72 out of reset).
    logic [15:0] held_pair = '0;
    logic [1:0]  held_num = '0;
    logic [6:0]  line_pos = '0;
    logic [6:0]  wrap_at = WRAP_RESET;

    task automatic report(input string msg);
        $display("ERROR at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // Six-bit value to its character in the standard alphabet.
    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        if (v <= 6'd25)
            return 8'h41 + {2'b00, v};
        else if (v <= 6'd51)
            return 8'h61 + {2'b00, v - 6'd26};
        else if (v <= 6'd61)
            return 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            return CH_PLUS;
        return CH_SLASH;
    endfunction

    function automatic void owe_char(input logic [7:0] c, input logic fin);
        out_item_t o;
        o.out_char = c;
        o.last = fin;
        expected_chars.push_back(o);
    endfunction

    // Works out the characters one accepted transaction causes and advances the
    // held bytes and the line column the same way the encoder must.
    function automatic void encode_item(input in_item_t it);
        logic [23:0] grp;
        logic [7:0]  next_col;
        if (it.action == ACT_FLUSH)
        begin
            // An empty flush is silent. Otherwise pad the one or two held bytes.
            if (held_num == 2'd0)
                return;
            grp = (held_num == 2'd1) ? {held_pair[7:0], 16'h0000} : {held_pair, 8'h00};
            owe_char(b64_symbol(grp[23:18]), 1'b0);
            owe_char(b64_symbol(grp[17:12]), 1'b0);
            owe_char((held_num == 2'd1) ? CH_PAD : b64_symbol(grp[11:6]), 1'b0);
            owe_char(CH_PAD, 1'b1);
            held_num = 2'd0;
            held_pair = '0;
            return;
        end
        if (held_num < 2'd2)
        begin
            held_pair = {held_pair[7:0], it.data_byte};
            held_num = held_num + 2'd1;
            return;
        end
        grp = {held_pair, it.data_byte};
        held_pair = '0;
        held_num = 2'd0;
        // The column is widened by one bit so a wrap setting near 127 cannot overflow.
        next_col = {1'b0, line_pos} + 8'd4;
        owe_char(b64_symbol(grp[23:18]), 1'b0);
        owe_char(b64_symbol(grp[17:12]), 1'b0);
        owe_char(b64_symbol(grp[11:6]), 1'b0);
        if (next_col >= {1'b0, wrap_at})
        begin
            owe_char(b64_symbol(grp[5:0]), 1'b0);
            owe_char(CH_CR, 1'b0);
            owe_char(CH_LF, 1'b1);
            line_pos = '0;
        end
        else
        begin
            owe_char(b64_symbol(grp[5:0]), 1'b1);
            line_pos = next_col[6:0];
        end
    endfunction

    // Source driver. It works at the falling edge so the encoder sees stable
    // inputs at every rising edge. A new item is only offered once the previous
    // one was taken, so valid never drops while an item is waiting.
    int src_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n && (!src_valid || src_taken))
        begin
            if (src_gap != 0)
            begin
                src_gap--;
                src_valid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                src_item <= byte_queue.pop_front();
                src_valid <= 1'b1;
                // A gap, when drawn, starts once this item has been taken.
                if (idle_on && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 18);
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
    end

    // Sink driver. Random stall bursts while idling is on, and one long hold-off
    // on request, counted here so that the sender keeps pushing meanwhile.
    int dst_gap = 0;
    int hold_left = 0;
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            dst_ready <= 1'b0;
        end
        else if (dst_gap != 0)
        begin
            dst_gap--;
            dst_ready <= 1'b0;
        end
        else
        begin
            dst_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 11) == 0)
                dst_gap = $urandom_range(1, 18);
        end
    end

    // Monitor. Samples both handshakes at the rising edge. The prediction for an
    // accepted source transaction is made before any output of the same edge is
    // checked, so the expectation is always in place in time.
    always @(posedge clk)
    begin
        out_item_t want;
        src_taken <= rst_n && src_valid && src_ready;
        if (rst_n && src_valid && src_ready)
        begin
            encode_item(src_item);
            items_taken++;
        end
        if (rst_n && dst_valid && dst_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report($sformatf("unexpected character 0x%02h last=%0b",
                                 dst_item.out_char, dst_item.last));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (dst_item.out_char !== want.out_char)
                    report($sformatf("out_char 0x%02h, wanted 0x%02h",
                                     dst_item.out_char, want.out_char));
                if (dst_item.last !== want.last)
                    report($sformatf("last %0b, wanted %0b on char 0x%02h",
                                     dst_item.last, want.last, want.out_char));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("base64_line_wrap_encoder: mismatch");
            $finish;
        end
    end

    task automatic queue_item(input logic act, input logic [7:0] b);
        in_item_t it;
        it.action = act;
        it.data_byte = b;
        byte_queue.push_back(it);
        items_queued++;
    endtask

    // Mostly data bytes with an occasional flush; corner bytes show up now and then
    // so the all-zero and all-one sextets keep appearing. A flush carries a random
    // byte, which the encoder must ignore.
    task automatic queue_random(input int count, input int flush_odds);
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 15))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(1, flush_odds) == 1)
                queue_item(ACT_FLUSH, b);
            else
                queue_item(ACT_DATA, b);
        end
    endtask

    // Waits until every queued transaction has been taken and every owed
    // character has come out, then lets the encoder settle in case it is
    // still absorbing a byte that produced no output.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_taken != items_queued || expected_chars.size() != 0);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    // Writes the wrap column while the encoder is idle.
    task automatic set_wrap(input logic [6:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        wrap_at = v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset wrap of 72: all-zero, all-one and all-plus
        // groups, then flushes with nothing held, one byte held and two held.
        queue_item(ACT_DATA, 8'h00);
        queue_item(ACT_DATA, 8'h00);
        queue_item(ACT_DATA, 8'h00);
        queue_item(ACT_DATA, 8'hFF);
        queue_item(ACT_DATA, 8'hFF);
        queue_item(ACT_DATA, 8'hFF);
        queue_item(ACT_DATA, 8'hFB);
        queue_item(ACT_DATA, 8'hEF);
        queue_item(ACT_DATA, 8'hBE);
        queue_item(ACT_FLUSH, 8'hA5);
        queue_item(ACT_DATA, 8'h4D);
        queue_item(ACT_FLUSH, 8'hFF);
        queue_item(ACT_DATA, 8'h4D);
        queue_item(ACT_DATA, 8'h61);
        queue_item(ACT_FLUSH, 8'h00);
        wait_drained();

        // Smallest wrap: every full group is followed by CR LF, a padded flush is not.
        set_wrap(7'd4);
        queue_item(ACT_DATA, 8'h12);
        queue_item(ACT_DATA, 8'h34);
        queue_item(ACT_DATA, 8'h56);
        queue_item(ACT_DATA, 8'h78);
        queue_item(ACT_DATA, 8'h9A);
        queue_item(ACT_DATA, 8'hBC);
        queue_item(ACT_DATA, 8'hFF);
        queue_item(ACT_FLUSH, 8'h5A);
        wait_drained();

        // Largest wrap: enough whole groups to walk the column all the way round.
        set_wrap(7'd127);
        queue_random(110, 24);
        wait_drained();

        // Usual MIME line length, starting with a long sink hold-off so the
        // internal queue fills and the source side is pushed back.
        set_wrap(7'd76);
        hold_request = LONG_HOLD;
        queue_random(40, 8);
        wait_drained();

        set_wrap(7'($urandom_range(4, 127)));
        queue_random(30, 6);
        wait_drained();

        set_wrap(7'd4);
        queue_random(20, 5);
        wait_drained();

        // Last stretch back at the reset value, with both sides running flat out.
        set_wrap(WRAP_RESET);
        idle_on = 1'b0;
        queue_random(30, 8);
        wait_drained();
        repeat (20) @(negedge clk);

        if (errors == 0 && expected_chars.size() == 0)
            $display("base64_line_wrap_encoder: match");
        else
            $display("base64_line_wrap_encoder: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/b64lw_pkg.sv
hdl/b64lw_front.sv
hdl/b64lw_queue.sv
hdl/b64lw_back.sv
hdl/base64_line_wrap_encoder.sv
bench/base64_line_wrap_encoder_test.sv
